>>> sv/touch_gesture_classifier_macros.svh
// shared assertion macros, sampled on clk and off while rst_n is low
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// property that must hold at every edge
`define TGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/tgc_pkg.sv
package tgc_pkg;

  localparam int COORD_BITS = 12;
  localparam int TIME_BITS  = 32;
  localparam int THR_W      = 8;
  localparam int MS_W       = 16;
  localparam int SPAN_W     = 12;
  localparam int STEPS_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = COORD_BITS + STEPS_W;

  localparam logic [TIME_BITS-1:0] MIN_TAP_MS = TIME_BITS'(50);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_HOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DTAP_WINDOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_STEPS  = 3'd6;

  typedef enum logic [2:0] {
    DIR_STAY    = 3'd0,
    DIR_REQUEST = 3'd1,
    DIR_LEFT    = 3'd2,
    DIR_RIGHT   = 3'd3,
    DIR_UP      = 3'd4,
    DIR_DOWN    = 3'd5
  } dir_t;

  typedef enum logic [1:0] {
    DISP_PLAYER   = 2'd0,
    DISP_VOLUME   = 2'd1,
    DISP_STATIONS = 2'd2,
    DISP_OTHER    = 2'd3
  } disp_mode_t;

  typedef enum logic [1:0] {
    MREQ_NONE     = 2'd0,
    MREQ_VOLUME   = 2'd1,
    MREQ_STATIONS = 2'd2,
    MREQ_SLEEP    = 2'd3
  } mreq_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_INC  = 2'd1,
    STEP_DEC  = 2'd2
  } step_t;

  typedef enum logic [1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_DOUBLE = 2'd1,
    CLICK_SINGLE = 2'd2
  } click_t;

  typedef struct packed {
    logic [THR_W-1:0]   swipe_threshold;
    logic [MS_W-1:0]    cooldown_time;
    logic [MS_W-1:0]    sleep_hold_time;
    logic [MS_W-1:0]    double_tap_window;
    logic [SPAN_W-1:0]  screen_width;
    logic [SPAN_W-1:0]  screen_height;
    logic [STEPS_W-1:0] drag_steps;
  } cfg_t;

  typedef struct packed {
    logic                  touched;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [TIME_BITS-1:0]  now_ms;
    disp_mode_t            display_mode;
    logic                  offline_mode;
  } item_t;

  typedef struct packed {
    logic   accepted;
    mreq_t  mode_request;
    step_t  step_event;
    click_t click;
    logic   deep_sleep;
  } res_t;

endpackage

>>> sv/tgc_cfg_regs.sv
module tgc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tgc_pkg::cfg_t                    cfg
);
  import tgc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWIPE_THR:   cfg_nxt.swipe_threshold   = cfg_wdata[THR_W-1:0];
        CFG_COOLDOWN:    cfg_nxt.cooldown_time     = cfg_wdata[MS_W-1:0];
        CFG_SLEEP_HOLD:  cfg_nxt.sleep_hold_time   = cfg_wdata[MS_W-1:0];
        CFG_DTAP_WINDOW: cfg_nxt.double_tap_window = cfg_wdata[MS_W-1:0];
        CFG_SCR_WIDTH:   cfg_nxt.screen_width      = cfg_wdata[SPAN_W-1:0];
        CFG_SCR_HEIGHT:  cfg_nxt.screen_height     = cfg_wdata[SPAN_W-1:0];
        CFG_DRAG_STEPS:  cfg_nxt.drag_steps        = cfg_wdata[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_threshold   <= THR_W'(12);
      cfg_r.cooldown_time     <= MS_W'(150);
      cfg_r.sleep_hold_time   <= MS_W'(5000);
      cfg_r.double_tap_window <= MS_W'(400);
      cfg_r.screen_width      <= SPAN_W'(320);
      cfg_r.screen_height     <= SPAN_W'(240);
      cfg_r.drag_steps        <= STEPS_W'(40);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/tgc_drag_step.sv
module tgc_drag_step (
  input  logic [tgc_pkg::COORD_BITS-1:0] anchor,
  input  logic [tgc_pkg::COORD_BITS-1:0] pos,
  input  logic [tgc_pkg::SPAN_W-1:0]     span,
  input  logic [tgc_pkg::STEPS_W-1:0]    steps,
  output logic                           hit,
  output tgc_pkg::step_t                 ev
);
  import tgc_pkg::*;

  logic [COORD_BITS-1:0] delta;
  logic [SPAN_W-1:0]     span_eff;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     twice_span;

  assign delta    = (pos > anchor) ? (pos - anchor) : (anchor - pos);
  // zero span counts as one
  assign span_eff = (span == '0) ? SPAN_W'(1) : span;
  assign prod     = PROD_W'(delta) * PROD_W'(steps);
  // delta*steps/span > 1 is the same as delta*steps >= 2*span
  assign twice_span = PROD_W'({span_eff, 1'b0});
  assign hit      = (prod >= twice_span);
  assign ev       = (pos > anchor) ? STEP_INC : STEP_DEC;

endmodule

>>> sv/tgc_core.sv
module tgc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  tgc_pkg::item_t item,
  input  tgc_pkg::cfg_t  cfg,
  output tgc_pkg::res_t  res
);
  import tgc_pkg::*;

  function automatic logic [TIME_BITS-1:0] elapsed(input logic [TIME_BITS-1:0] now,
                                                   input logic [TIME_BITS-1:0] then_t);
    return now - then_t;
  endfunction

  logic                  was_touched_r, was_touched_nxt;
  dir_t                  dir_r, dir_nxt;
  logic [TIME_BITS-1:0]  press_start_r, press_start_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  logic [COORD_BITS-1:0] vol_anchor_r, vol_anchor_nxt;
  logic [COORD_BITS-1:0] sta_anchor_r, sta_anchor_nxt;
  logic                  tap_pending_r, tap_pending_nxt;
  logic [TIME_BITS-1:0]  tap_time_r, tap_time_nxt;
  logic                  double_tap_r, double_tap_nxt;
  logic [TIME_BITS-1:0]  release_time_r, release_time_nxt;
  logic                  release_armed_r, release_armed_nxt;

  logic [COORD_BITS-1:0] ax, ay, thr;
  dir_t                  picked;
  dir_t                  dir_cur;
  logic                  hit_x, hit_y;
  step_t                 ev_x, ev_y;
  logic [TIME_BITS-1:0]  held, el_release, el_tap;
  logic                  ignore;

  // swipe direction from the press start point
  assign ax  = (item.pos_x > start_x_r) ? (item.pos_x - start_x_r) : (start_x_r - item.pos_x);
  assign ay  = (item.pos_y > start_y_r) ? (item.pos_y - start_y_r) : (start_y_r - item.pos_y);
  assign thr = COORD_BITS'(cfg.swipe_threshold);

  always_comb begin
    if (ax > thr || ay > thr) begin
      if (ax > ay) begin
        picked = (item.pos_x > start_x_r) ? DIR_RIGHT : DIR_LEFT;
      end else begin
        picked = (item.pos_y > start_y_r) ? DIR_DOWN : DIR_UP;
      end
    end else begin
      picked = DIR_REQUEST;
    end
  end

  tgc_drag_step u_step_x (
    .anchor (vol_anchor_r),
    .pos    (item.pos_x),
    .span   (cfg.screen_width),
    .steps  (cfg.drag_steps),
    .hit    (hit_x),
    .ev     (ev_x)
  );

  tgc_drag_step u_step_y (
    .anchor (sta_anchor_r),
    .pos    (item.pos_y),
    .span   (cfg.screen_height),
    .steps  (cfg.drag_steps),
    .hit    (hit_y),
    .ev     (ev_y)
  );

  assign held       = elapsed(item.now_ms, press_start_r);
  assign el_release = elapsed(item.now_ms, release_time_r);
  assign ignore     = item.touched && !tap_pending_r && release_armed_r &&
                      (el_release < TIME_BITS'(cfg.cooldown_time));

  always_comb begin
    was_touched_nxt   = was_touched_r;
    dir_nxt           = dir_r;
    press_start_nxt   = press_start_r;
    start_x_nxt       = start_x_r;
    start_y_nxt       = start_y_r;
    vol_anchor_nxt    = vol_anchor_r;
    sta_anchor_nxt    = sta_anchor_r;
    tap_pending_nxt   = tap_pending_r;
    tap_time_nxt      = tap_time_r;
    double_tap_nxt    = double_tap_r;
    release_time_nxt  = release_time_r;
    release_armed_nxt = release_armed_r;
    dir_cur           = dir_r;
    el_tap            = '0;
    res               = '0;
    res.accepted      = 1'b1;

    if (item.touched) begin
      if (ignore) begin
        res.accepted = 1'b0;
      end else begin
        release_armed_nxt = 1'b0;
        was_touched_nxt   = 1'b1;
        if (!was_touched_r) begin
          // press start
          if (tap_pending_r &&
              elapsed(item.now_ms, tap_time_r) < TIME_BITS'(cfg.double_tap_window)) begin
            double_tap_nxt = 1'b1;
          end
          tap_pending_nxt = 1'b0;
          start_x_nxt     = item.pos_x;
          start_y_nxt     = item.pos_y;
          vol_anchor_nxt  = item.pos_x;
          sta_anchor_nxt  = item.pos_y;
          dir_nxt         = DIR_REQUEST;
          press_start_nxt = item.now_ms;
        end else begin
          if (dir_r == DIR_REQUEST) begin
            dir_cur = picked;
            if (picked != DIR_REQUEST) begin
              tap_pending_nxt = 1'b0;
              double_tap_nxt  = 1'b0;
            end
          end
          dir_nxt = dir_cur;
          if (dir_cur == DIR_REQUEST && held >= TIME_BITS'(cfg.sleep_hold_time) &&
              !item.offline_mode) begin
            res.mode_request = MREQ_SLEEP;
          end
          if (dir_cur == DIR_LEFT || dir_cur == DIR_RIGHT) begin
            press_start_nxt = item.now_ms;
            if (item.display_mode == DISP_PLAYER || item.display_mode == DISP_VOLUME) begin
              res.mode_request = MREQ_VOLUME;
              if (hit_x) begin
                res.step_event = ev_x;
                vol_anchor_nxt = item.pos_x;
              end
            end
          end else if (dir_cur == DIR_UP || dir_cur == DIR_DOWN) begin
            press_start_nxt = item.now_ms;
            if (item.display_mode == DISP_PLAYER || item.display_mode == DISP_STATIONS) begin
              res.mode_request = MREQ_STATIONS;
              if (hit_y) begin
                res.step_event = ev_y;
                sta_anchor_nxt = item.pos_y;
              end
            end
          end
        end
      end
    end else begin
      was_touched_nxt = 1'b0;
      if (was_touched_r) begin
        // release
        if (dir_r == DIR_REQUEST) begin
          if (held >= TIME_BITS'(cfg.sleep_hold_time)) begin
            res.deep_sleep = 1'b1;
          end else if (held > MIN_TAP_MS) begin
            if (double_tap_r) begin
              res.click      = CLICK_DOUBLE;
              double_tap_nxt = 1'b0;
            end else begin
              tap_pending_nxt = 1'b1;
              tap_time_nxt    = item.now_ms;
            end
          end
        end
        dir_nxt           = DIR_STAY;
        release_time_nxt  = item.now_ms;
        release_armed_nxt = 1'b1;
      end
      // lone tap turns into a play click once the window runs out
      el_tap = elapsed(item.now_ms, tap_time_nxt);
      if (tap_pending_nxt && el_tap >= TIME_BITS'(cfg.double_tap_window)) begin
        res.click       = CLICK_SINGLE;
        tap_pending_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_touched_r   <= 1'b1;
      dir_r           <= DIR_STAY;
      press_start_r   <= '0;
      start_x_r       <= '0;
      start_y_r       <= '0;
      vol_anchor_r    <= '0;
      sta_anchor_r    <= '0;
      tap_pending_r   <= 1'b0;
      tap_time_r      <= '0;
      double_tap_r    <= 1'b0;
      release_time_r  <= '0;
      release_armed_r <= 1'b0;
    end else if (fire) begin
      was_touched_r   <= was_touched_nxt;
      dir_r           <= dir_nxt;
      press_start_r   <= press_start_nxt;
      start_x_r       <= start_x_nxt;
      start_y_r       <= start_y_nxt;
      vol_anchor_r    <= vol_anchor_nxt;
      sta_anchor_r    <= sta_anchor_nxt;
      tap_pending_r   <= tap_pending_nxt;
      tap_time_r      <= tap_time_nxt;
      double_tap_r    <= double_tap_nxt;
      release_time_r  <= release_time_nxt;
      release_armed_r <= release_armed_nxt;
    end
  end

endmodule

>>> sv/touch_gesture_classifier.sv
// touch gesture classifier: one touch sample in, one gesture result out
// input channel: in_valid/in_stall with the sample fields (touched, x, y,
//   ms timestamp, display mode, offline flag); an item is taken at an edge
//   with in_valid high and in_stall low
// output channel: out_valid/out_stall with accepted, mode request, step
//   event, click and deep sleep; every input item yields exactly one result
// config: cfg_we writes cfg_wdata into register cfg_index at the edge; the user
//   must write only while no item is in flight, unchecked by the block;
//   unknown indexes are dropped
// path: sample register, classification, result register driving the outputs
// throughput: one item per cycle while out_stall is low, set by the single
//   classify stage that reads and updates the gesture state in the same cycle
// stall: while out_stall holds a waiting result, the sample register keeps
//   one more item and then in_stall is raised; nothing is dropped
// reset (rst_n low, synchronous): channels empty, config back to defaults,
//   gesture state idle with the panel treated as already touched, so a touch
//   held through reset gives no gesture until it is released once
module touch_gesture_classifier (
  input  logic                             clk,
  input  logic                             rst_n,
  // sample channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_touched,
  input  logic [tgc_pkg::COORD_BITS-1:0]   in_pos_x,
  input  logic [tgc_pkg::COORD_BITS-1:0]   in_pos_y,
  input  logic [tgc_pkg::TIME_BITS-1:0]    in_now_ms,
  input  logic [1:0]                       in_display_mode,
  input  logic                             in_offline_mode,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_accepted,
  output logic [1:0]                       out_mode_request,
  output logic [1:0]                       out_step_event,
  output logic [1:0]                       out_click,
  output logic                             out_deep_sleep,
  // config write port
  input  logic                             cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tgc_pkg::*;

  `include "touch_gesture_classifier_macros.svh"

  logic  in_valid_r, in_valid_nxt;
  item_t in_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  res_r;
  res_t  res;
  cfg_t  cfg;
  logic  advance;   // result register can take a new result
  logic  fire;      // sample register is classified this cycle
  logic  take;      // new sample enters

  tgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: the result register frees up when empty or when it is taken
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sample register, loaded whenever an item is taken
  always_ff @(posedge clk) begin
    if (take) begin
      in_r.touched      <= in_touched;
      in_r.pos_x        <= in_pos_x;
      in_r.pos_y        <= in_pos_y;
      in_r.now_ms       <= in_now_ms;
      in_r.display_mode <= disp_mode_t'(in_display_mode);
      in_r.offline_mode <= in_offline_mode;
    end
  end

  // gesture state and classification
  tgc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = res_r.accepted;
  assign out_mode_request = res_r.mode_request;
  assign out_step_event   = res_r.step_event;
  assign out_click        = res_r.click;
  assign out_deep_sleep   = res_r.deep_sleep;

  // a stalled sample stays in the sample register
  `TGC_ASSERT_NEXT(a_stall_keeps_item, in_stall, in_valid_r, "stalled sample was lost")
  // an ignored sample carries no gesture
  `TGC_ASSERT(a_ignored_clean, !(out_valid_r && !res_r.accepted) || (res_r.mode_request == MREQ_NONE && res_r.step_event == STEP_NONE && res_r.click == CLICK_NONE && !res_r.deep_sleep), "ignored sample reports a gesture")
  // a step only comes with a volume or stations request
  `TGC_ASSERT(a_step_has_mode, !(out_valid_r && res_r.step_event != STEP_NONE) || res_r.mode_request == MREQ_VOLUME || res_r.mode_request == MREQ_STATIONS, "step without drag mode")
  // deep sleep release never also clicks
  `TGC_ASSERT(a_sleep_no_click, !(out_valid_r && res_r.deep_sleep) || res_r.click == CLICK_NONE, "deep sleep with click")

endmodule

>>> test/touch_gesture_classifier_tb.sv
`timescale 1ns / 100ps

module touch_gesture_classifier_tb;
  import tgc_pkg::*;

  // how a directed row is checked: by the gesture tracker below, or against
  // a result that is obvious by hand
  typedef enum {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_IGNORED
  } row_check_t;

  typedef struct {
    bit         down;
    int         x;
    int         y;
    int         ms;
    disp_mode_t mode;
    bit         offline;
    row_check_t check;
  } script_row_t;

  localparam int PHASE_ITEMS = 78;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES = 3;
  localparam int PX_MAX = (1 << COORD_BITS) - 1;

  // clock, reset and block ports
  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_touched = 1'b0;
  logic [COORD_BITS-1:0] in_pos_x = '0;
  logic [COORD_BITS-1:0] in_pos_y = '0;
  logic [TIME_BITS-1:0]  in_now_ms = '0;
  logic [1:0]            in_display_mode = '0;
  logic                  in_offline_mode = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_accepted;
  logic [1:0] out_mode_request;
  logic [1:0] out_step_event;
  logic [1:0] out_click;
  logic       out_deep_sleep;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  touch_gesture_classifier dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_touched       (in_touched),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_now_ms        (in_now_ms),
    .in_display_mode  (in_display_mode),
    .in_offline_mode  (in_offline_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_mode_request (out_mode_request),
    .out_step_event   (out_step_event),
    .out_click        (out_click),
    .out_deep_sleep   (out_deep_sleep),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gesture tracker: our own copy of the classifier state and its registers
  cfg_t                  trk_cfg;
  logic                  trk_touched;
  dir_t                  trk_dir;
  logic [TIME_BITS-1:0]  trk_press_ms;
  logic [COORD_BITS-1:0] trk_org_x;
  logic [COORD_BITS-1:0] trk_org_y;
  logic [COORD_BITS-1:0] trk_vol_anchor;
  logic [COORD_BITS-1:0] trk_stn_anchor;
  logic                  trk_tap_wait;
  logic [TIME_BITS-1:0]  trk_tap_ms;
  logic                  trk_dbl;
  logic [TIME_BITS-1:0]  trk_rel_ms;
  logic                  trk_rel_armed;

  // gestures the block still owes us, oldest first
  res_t gesture_q[$];

  // traffic shaping, shared by the stimulus, sender and receiver
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  logic [TIME_BITS-1:0] panel_ms = '0;

  // tallies
  int mismatches = 0;
  int phase_taken = 0;
  int taken_total = 0;
  int ignored_total = 0;
  int step_total = 0;
  int single_total = 0;
  int double_total = 0;
  int sleep_req_total = 0;
  int deep_total = 0;

  // directed part: reset behavior, cooldown, taps, swipes on both axes,
  // wrong display mode, long hold with and without offline, short press
  script_row_t script [26] = '{
    // touch held through reset is dead until released once
    '{1'b1,  100,  100,  1000, DISP_PLAYER,   1'b0, ROW_QUIET},
    '{1'b0,  100,  100,  1010, DISP_PLAYER,   1'b0, ROW_QUIET},
    // new touch inside the release cooldown is dropped
    '{1'b1,  100,  100,  1050, DISP_PLAYER,   1'b0, ROW_IGNORED},
    '{1'b1,    0, 4095,  1300, DISP_PLAYER,   1'b0, ROW_QUIET},
    '{1'b1,    0, 4095,  1310, DISP_VOLUME,   1'b1, ROW_PREDICT},
    // tap, then a second tap inside the window gives the mode click
    '{1'b0,    0, 4095,  1400, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b1,    0, 4095,  1450, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b0,    0, 4095,  1560, DISP_PLAYER,   1'b0, ROW_PREDICT},
    // lone tap at the far corner, play click once the window runs out
    '{1'b1, 4095,    0,  2200, DISP_OTHER,    1'b0, ROW_PREDICT},
    '{1'b0, 4095,    0,  2300, DISP_OTHER,    1'b0, ROW_PREDICT},
    '{1'b0, 4095,    0,  2800, DISP_PLAYER,   1'b0, ROW_PREDICT},
    // horizontal swipe: lock right, step up, step down, then wrong mode
    '{1'b1,  160,  120,  3000, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b1,  180,  121,  3020, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b1,  100,  121,  3040, DISP_VOLUME,   1'b0, ROW_PREDICT},
    '{1'b1, 4095,  121,  3060, DISP_STATIONS, 1'b0, ROW_PREDICT},
    '{1'b0, 4095,  121,  3080, DISP_PLAYER,   1'b0, ROW_PREDICT},
    // vertical swipe: lock up, step down, step up to the bottom edge
    '{1'b1,   50,  200,  3300, DISP_STATIONS, 1'b0, ROW_PREDICT},
    '{1'b1,   50,  100,  3320, DISP_STATIONS, 1'b0, ROW_PREDICT},
    '{1'b1,   50, 4095,  3340, DISP_STATIONS, 1'b0, ROW_PREDICT},
    '{1'b0,   50, 4095,  3360, DISP_PLAYER,   1'b0, ROW_PREDICT},
    // long still hold: sleep request, none when offline, deep sleep on release
    '{1'b1, 2000, 2000, 10000, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b1, 2000, 2000, 15000, DISP_OTHER,    1'b0, ROW_PREDICT},
    '{1'b1, 2000, 2000, 15100, DISP_PLAYER,   1'b1, ROW_PREDICT},
    '{1'b0, 2000, 2000, 16000, DISP_PLAYER,   1'b0, ROW_PREDICT},
    // press of exactly the minimum tap length is not a tap
    '{1'b1,  700,  700, 17000, DISP_PLAYER,   1'b0, ROW_PREDICT},
    '{1'b0,  700,  700, 17050, DISP_PLAYER,   1'b0, ROW_PREDICT}
  };

  task automatic tracker_reset();
    trk_cfg.swipe_threshold   = 8'd12;
    trk_cfg.cooldown_time     = 16'd150;
    trk_cfg.sleep_hold_time   = 16'd5000;
    trk_cfg.double_tap_window = 16'd400;
    trk_cfg.screen_width      = 12'd320;
    trk_cfg.screen_height     = 12'd240;
    trk_cfg.drag_steps        = 8'd40;
    trk_touched    = 1'b1;
    trk_dir        = DIR_STAY;
    trk_press_ms   = '0;
    trk_org_x      = '0;
    trk_org_y      = '0;
    trk_vol_anchor = '0;
    trk_stn_anchor = '0;
    trk_tap_wait   = 1'b0;
    trk_tap_ms     = '0;
    trk_dbl        = 1'b0;
    trk_rel_ms     = '0;
    trk_rel_armed  = 1'b0;
  endtask

  // direction locks once either axis moves past the threshold
  function automatic dir_t swipe_direction(logic [COORD_BITS-1:0] x,
                                           logic [COORD_BITS-1:0] y);
    int ax;
    int ay;
    ax = (x > trk_org_x) ? int'(x - trk_org_x) : int'(trk_org_x - x);
    ay = (y > trk_org_y) ? int'(y - trk_org_y) : int'(trk_org_y - y);
    if (ax > int'(trk_cfg.swipe_threshold) || ay > int'(trk_cfg.swipe_threshold)) begin
      if (ax > ay) return (x > trk_org_x) ? DIR_RIGHT : DIR_LEFT;
      return (y > trk_org_y) ? DIR_DOWN : DIR_UP;
    end
    return DIR_REQUEST;
  endfunction

  // scaled drag from the anchor; a step fires at two units or more and moves it
  function automatic step_t drag_step(inout logic [COORD_BITS-1:0] anchor,
                                      input logic [COORD_BITS-1:0] pos,
                                      input logic [SPAN_W-1:0] span);
    int unsigned delta;
    int unsigned div;
    step_t ev;
    delta = (anchor > pos) ? int'(anchor - pos) : int'(pos - anchor);
    div   = (span == '0) ? 1 : int'(span);
    if ((delta * int'(trk_cfg.drag_steps)) / div > 1) begin
      ev = (pos > anchor) ? STEP_INC : STEP_DEC;
      anchor = pos;
      return ev;
    end
    return STEP_NONE;
  endfunction

  // advance the tracker by one sample and return the gesture it reports
  function automatic res_t classify_sample(item_t s);
    res_t r;
    logic [TIME_BITS-1:0] since_rel;
    logic [TIME_BITS-1:0] since_tap;
    logic [TIME_BITS-1:0] held;
    r = '0;
    r.accepted = 1'b1;
    since_rel = s.now_ms - trk_rel_ms;
    held = s.now_ms - trk_press_ms;
    if (s.touched) begin
      // cooldown: nothing at all changes
      if (!trk_tap_wait && trk_rel_armed &&
          since_rel < TIME_BITS'(trk_cfg.cooldown_time)) begin
        return '0;
      end
      trk_rel_armed = 1'b0;
      if (!trk_touched) begin
        since_tap = s.now_ms - trk_tap_ms;
        if (trk_tap_wait && since_tap < TIME_BITS'(trk_cfg.double_tap_window)) begin
          trk_dbl = 1'b1;
        end
        trk_tap_wait   = 1'b0;
        trk_org_x      = s.pos_x;
        trk_org_y      = s.pos_y;
        trk_vol_anchor = s.pos_x;
        trk_stn_anchor = s.pos_y;
        trk_dir        = DIR_REQUEST;
        trk_press_ms   = s.now_ms;
      end else begin
        if (trk_dir == DIR_REQUEST) begin
          trk_dir = swipe_direction(s.pos_x, s.pos_y);
          if (trk_dir != DIR_REQUEST) begin
            trk_tap_wait = 1'b0;
            trk_dbl      = 1'b0;
          end
        end
        if (trk_dir == DIR_REQUEST && held >= TIME_BITS'(trk_cfg.sleep_hold_time) &&
            !s.offline_mode) begin
          r.mode_request = MREQ_SLEEP;
        end
        if (trk_dir == DIR_LEFT || trk_dir == DIR_RIGHT) begin
          trk_press_ms = s.now_ms;
          if (s.display_mode == DISP_PLAYER || s.display_mode == DISP_VOLUME) begin
            r.mode_request = MREQ_VOLUME;
            r.step_event = drag_step(trk_vol_anchor, s.pos_x, trk_cfg.screen_width);
          end
        end else if (trk_dir == DIR_UP || trk_dir == DIR_DOWN) begin
          trk_press_ms = s.now_ms;
          if (s.display_mode == DISP_PLAYER || s.display_mode == DISP_STATIONS) begin
            r.mode_request = MREQ_STATIONS;
            r.step_event = drag_step(trk_stn_anchor, s.pos_y, trk_cfg.screen_height);
          end
        end
      end
    end else begin
      if (trk_touched) begin
        // release of a still press: deep sleep, double click or a pending tap
        if (trk_dir == DIR_REQUEST) begin
          if (held >= TIME_BITS'(trk_cfg.sleep_hold_time)) begin
            r.deep_sleep = 1'b1;
          end else if (held > MIN_TAP_MS) begin
            if (trk_dbl) begin
              r.click = CLICK_DOUBLE;
              trk_dbl = 1'b0;
            end else begin
              trk_tap_wait = 1'b1;
              trk_tap_ms   = s.now_ms;
            end
          end
        end
        trk_dir       = DIR_STAY;
        trk_rel_ms    = s.now_ms;
        trk_rel_armed = 1'b1;
      end
      since_tap = s.now_ms - trk_tap_ms;
      if (trk_tap_wait && since_tap >= TIME_BITS'(trk_cfg.double_tap_window)) begin
        r.click = CLICK_SINGLE;
        trk_tap_wait = 1'b0;
      end
    end
    trk_touched = s.touched;
    return r;
  endfunction

  // offer one sample and hold it until taken; called just after a rising edge
  task automatic drive_sample(input item_t s, input row_check_t how);
    res_t want;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_touched      <= s.touched;
    in_pos_x        <= s.pos_x;
    in_pos_y        <= s.pos_y;
    in_now_ms       <= s.now_ms;
    in_display_mode <= s.display_mode;
    in_offline_mode <= s.offline_mode;
    // stall is stable between edges, so the falling edge tells what the next
    // rising edge will do
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    want = classify_sample(s);
    phase_taken++;
    if (want.accepted) begin
      taken_total++;
    end else begin
      ignored_total++;
    end
    if (want.step_event != STEP_NONE) step_total++;
    if (want.click == CLICK_SINGLE) single_total++;
    if (want.click == CLICK_DOUBLE) double_total++;
    if (want.mode_request == MREQ_SLEEP) sleep_req_total++;
    if (want.deep_sleep) deep_total++;
    case (how)
      ROW_QUIET: begin
        want = '0;
        want.accepted = 1'b1;
      end
      ROW_IGNORED: want = '0;
      default: ;
    endcase
    gesture_q.push_back(want);
    @(posedge clk);
  endtask

  function automatic int clamp_px(int v);
    if (v < 0) return 0;
    if (v > PX_MAX) return PX_MAX;
    return v;
  endfunction

  // a time offset at, just around, or well on either side of a boundary
  function automatic logic [TIME_BITS-1:0] near(logic [TIME_BITS-1:0] mark);
    case ($urandom_range(4))
      0: return (mark == '0) ? '0 : mark - 1'b1;
      1: return mark;
      2: return mark + 1'b1;
      3: return TIME_BITS'($urandom_range(mark));
      default: return mark + TIME_BITS'($urandom_range(300));
    endcase
  endfunction

  task automatic sample_at(input bit down, input int x, input int y,
                           input logic [TIME_BITS-1:0] dt);
    item_t s;
    panel_ms       = panel_ms + dt;
    s.touched      = down;
    s.pos_x        = COORD_BITS'(clamp_px(x));
    s.pos_y        = COORD_BITS'(clamp_px(y));
    s.now_ms       = panel_ms;
    s.display_mode = disp_mode_t'($urandom_range(3));
    s.offline_mode = ($urandom_range(4) == 0);
    drive_sample(s, ROW_PREDICT);
  endtask

  // one random gesture: mostly well-formed presses with random timing near
  // the boundaries, some idle stretches and a little noise
  task automatic play_gesture();
    int x;
    int y;
    int d;
    int sel;
    int thr;
    item_t s;
    x   = $urandom_range(PX_MAX);
    y   = $urandom_range(PX_MAX);
    thr = int'(trk_cfg.swipe_threshold);
    sel = $urandom_range(9);
    case (sel)
      0, 1: begin
        // single tap, maybe with jitter under the threshold
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.cooldown_time)));
        if ($urandom_range(1)) sample_at(1'b1, x + $urandom_range(thr), y, $urandom_range(40));
        sample_at(1'b0, x, y, near(MIN_TAP_MS));
      end
      2: begin
        // double tap
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.cooldown_time)));
        sample_at(1'b0, x, y, near(MIN_TAP_MS));
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.double_tap_window)));
        sample_at(1'b0, x, y, near(MIN_TAP_MS));
      end
      3, 4, 5, 6: begin
        // swipe along one axis; first move often right at the threshold
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.cooldown_time)));
        d = $urandom_range(1) ? thr + $urandom_range(1) : $urandom_range(1, 80);
        repeat ($urandom_range(2, 7)) begin
          if ($urandom_range(1)) d = -d;
          if (sel < 5) x = clamp_px(x + d);
          else y = clamp_px(y + d);
          sample_at(1'b1, x, y, $urandom_range(5, 40));
          d = $urandom_range(1, 60);
        end
        sample_at(1'b0, x, y, $urandom_range(5, 40));
      end
      7: begin
        // long still hold around the sleep time
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.cooldown_time)));
        sample_at(1'b1, x, y, near(TIME_BITS'(trk_cfg.sleep_hold_time)));
        sample_at(1'b1, x, y, $urandom_range(100));
        sample_at(1'b0, x, y, $urandom_range(100));
      end
      8: begin
        // untouched samples, lets a pending tap run out
        repeat ($urandom_range(1, 3))
          sample_at(1'b0, x, y, near(TIME_BITS'(trk_cfg.double_tap_window)));
      end
      default: begin
        // noise: every field random, timestamp jumps anywhere
        s.touched      = 1'($urandom_range(1));
        s.pos_x        = COORD_BITS'($urandom());
        s.pos_y        = COORD_BITS'($urandom());
        s.now_ms       = TIME_BITS'($urandom());
        s.display_mode = disp_mode_t'($urandom_range(3));
        s.offline_mode = 1'($urandom_range(1));
        panel_ms       = s.now_ms;
        drive_sample(s, ROW_PREDICT);
      end
    endcase
  endtask

  // stop offering and wait until every owed gesture is back
  task automatic settle();
    in_valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{CFG_SWIPE_THR, CFG_COOLDOWN, CFG_SLEEP_HOLD, CFG_DTAP_WINDOW,
            CFG_SCR_WIDTH, CFG_SCR_HEIGHT, CFG_DRAG_STEPS};
    val = '{CFG_DATA_W'(c.swipe_threshold), CFG_DATA_W'(c.cooldown_time),
            CFG_DATA_W'(c.sleep_hold_time), CFG_DATA_W'(c.double_tap_window),
            CFG_DATA_W'(c.screen_width), CFG_DATA_W'(c.screen_height),
            CFG_DATA_W'(c.drag_steps)};
    settle();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    trk_cfg = c;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.swipe_threshold   = THR_W'($urandom_range(2, 30));
    c.cooldown_time     = MS_W'($urandom_range(300));
    c.sleep_hold_time   = MS_W'($urandom_range(100, 3000));
    c.double_tap_window = MS_W'($urandom_range(50, 600));
    c.screen_width      = SPAN_W'($urandom_range(1, PX_MAX));
    c.screen_height     = SPAN_W'($urandom_range(1, PX_MAX));
    c.drag_steps        = STEPS_W'($urandom_range(1, 255));
    return c;
  endfunction

  // random gestures until enough samples were sent; with squeeze set the
  // receiver is told once to hold off while we keep sending
  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input bit squeeze);
    bit squeezed;
    squeezed    = 1'b0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    phase_taken = 0;
    while (phase_taken < PHASE_ITEMS) begin
      if (squeeze && !squeezed && phase_taken >= 20) begin
        hold_req = 1'b1;
        squeezed = 1'b1;
      end
      play_gesture();
    end
  endtask

  // receiver: random stall, or one long counted hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
    end
  end

  // result checker: a result is taken at the next rising edge when valid is
  // high and stall low, both stable at the falling edge
  always @(negedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.accepted     = out_accepted;
      got.mode_request = mreq_t'(out_mode_request);
      got.step_event   = step_t'(out_step_event);
      got.click        = click_t'(out_click);
      got.deep_sleep   = out_deep_sleep;
      if (gesture_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: acc=%0b mode=%0d step=%0d click=%0d deep=%0b",
                   got.accepted, got.mode_request, got.step_event, got.click,
                   got.deep_sleep);
      end else begin
        want = gesture_q.pop_front();
        if (got.accepted !== want.accepted || got.mode_request !== want.mode_request ||
            got.step_event !== want.step_event || got.click !== want.click ||
            got.deep_sleep !== want.deep_sleep) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: expected acc=%0b mode=%0d step=%0d click=%0d deep=%0b",
                     $realtime, want.accepted, want.mode_request, want.step_event,
                     want.click, want.deep_sleep);
            $display("                  got acc=%0b mode=%0d step=%0d click=%0d deep=%0b",
                     got.accepted, got.mode_request, got.step_event, got.click,
                     got.deep_sleep);
          end
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    item_t s;
    cfg_t  c;
    int    leftover;
    tracker_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles often, receiver stalls most of the time
    tx_idle_pct = 32;
    rx_idle_pct = 83;
    foreach (script[i]) begin
      s.touched      = script[i].down;
      s.pos_x        = COORD_BITS'(script[i].x);
      s.pos_y        = COORD_BITS'(script[i].y);
      s.now_ms       = TIME_BITS'(script[i].ms);
      s.display_mode = script[i].mode;
      s.offline_mode = script[i].offline;
      panel_ms       = s.now_ms;
      drive_sample(s, script[i].check);
    end
    run_phase(32, 83, 1'b0);

    // one extreme: zero threshold and cooldown, longest windows, zero height
    c.swipe_threshold   = '0;
    c.cooldown_time     = '0;
    c.sleep_hold_time   = '1;
    c.double_tap_window = '1;
    c.screen_width      = '1;
    c.screen_height     = '0;
    c.drag_steps        = '1;
    load_config(c);
    run_phase(32, 83, 1'b0);

    // the other extreme, now with the idling swapped
    c.swipe_threshold   = '1;
    c.cooldown_time     = '1;
    c.sleep_hold_time   = '0;
    c.double_tap_window = '0;
    c.screen_width      = 12'd1;
    c.screen_height     = '1;
    c.drag_steps        = 8'd1;
    load_config(c);
    run_phase(83, 32, 1'b0);

    load_config(random_config());
    run_phase(83, 32, 1'b0);

    // reset values again, timestamp about to wrap, full rate with a long
    // receiver hold-off so the block backs up into its input
    c.swipe_threshold   = 8'd12;
    c.cooldown_time     = 16'd150;
    c.sleep_hold_time   = 16'd5000;
    c.double_tap_window = 16'd400;
    c.screen_width      = 12'd320;
    c.screen_height     = 12'd240;
    c.drag_steps        = 8'd40;
    load_config(c);
    panel_ms = 32'hFFFF_FE00;
    run_phase(0, 0, 1'b1);

    load_config(random_config());
    run_phase(0, 0, 1'b0);

    settle();
    repeat (10) @(posedge clk);
    leftover = gesture_q.size();
    $display("covered %0d samples taken and %0d dropped in cooldown over six register settings",
             taken_total, ignored_total);
    $display("gestures: %0d steps, %0d single and %0d double clicks,",
             step_total, single_total, double_total);
    $display("          %0d sleep requests, %0d deep sleeps", sleep_req_total, deep_total);
    if (mismatches == 0 && leftover == 0) begin
      $display("** touch_gesture_classifier: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, leftover);
      $display("** touch_gesture_classifier: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", gesture_q.size());
    $display("** touch_gesture_classifier: FAILED **");
    $finish;
  end

endmodule

>>> touch_gesture_classifier.f
+incdir+sv
sv/tgc_pkg.sv
sv/tgc_cfg_regs.sv
sv/tgc_drag_step.sv
sv/tgc_core.sv
sv/touch_gesture_classifier.sv
test/touch_gesture_classifier_tb.sv
